// File: src/bpwm_pkg.sv
// Package for the eight-channel Bresenham PWM core: fraction tables, opcodes
// and the per-channel command struct. No dependencies.
`default_nettype none

package bpwm_pkg;

    localparam int CHAN_MAX   = 8;
    localparam int LEVELS     = 32;
    localparam int IDX_W      = 5;
    localparam int NUM_W      = 5;
    localparam int DEN_W      = 6;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    typedef struct packed {
        logic             tick;
        logic             load;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } chan_cmd_t;

    // Reduced numerator for each brightness step; top entry is 1/1.
    function automatic logic [NUM_W-1:0] frac_num(input logic [IDX_W-1:0] idx);
        logic [NUM_W-1:0] n;
        case (idx)
            5'd0:  n = 5'h00;
            5'd31: n = 5'h01;
            default:
            begin
                if (idx[0])
                    n = idx;
                else if (idx[1])
                    n = {1'b0, idx[4:1]};
                else if (idx[2])
                    n = {2'b00, idx[4:2]};
                else if (idx[3])
                    n = {3'b000, idx[4:3]};
                else
                    n = 5'h01;
            end
        endcase
        return n;
    endfunction

    // Matching denominator: 32 shifted down by the trailing zeros of the index; the top entry is 1.
    function automatic logic [DEN_W-1:0] frac_den(input logic [IDX_W-1:0] idx);
        logic [DEN_W-1:0] d;
        case (idx)
            5'd0:  d = 6'h20;
            5'd31: d = 6'h01;
            default:
            begin
                if (idx[0])
                    d = 6'h20;
                else if (idx[1])
                    d = 6'h10;
                else if (idx[2])
                    d = 6'h08;
                else if (idx[3])
                    d = 6'h04;
                else
                    d = 6'h02;
            end
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// File: src/bpwm_chan.sv
// One PWM channel: fraction and error accumulator with its tick update.
// Depends on bpwm_pkg.
`default_nettype none

module bpwm_chan
    import bpwm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire chan_cmd_t cmd,
    output logic           on
);

    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [NUM_W-1:0] acc_reg, acc_next;
    logic [DEN_W-1:0] step;

    assign on = (acc_reg < num_reg);

    // Wraps modulo 64; only the low five bits are kept.
    assign step = {1'b0, acc_reg} + (on ? den_reg : DEN_W'(0)) - {1'b0, num_reg};

    always_comb
    begin
        num_next = num_reg;
        den_next = den_reg;
        acc_next = acc_reg;
        if (cmd.load)
        begin
            num_next = cmd.num;
            den_next = cmd.den;
            acc_next = '0;
        end
        else if (cmd.tick)
        begin
            acc_next = step[NUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg <= '0;
            den_reg <= '0;
            acc_reg <= '0;
        end
        else
        begin
            num_reg <= num_next;
            den_reg <= den_next;
            acc_reg <= acc_next;
        end
    end

endmodule

`default_nettype wire

// File: src/eight_channel_bresenham_pwm_core.sv
// Eight-channel Bresenham PWM core: input register, per-channel update, result register.
// Depends on bpwm_pkg and bpwm_chan.
// A tick transaction passes through the input register, then its pattern shows from the result register.
// Throughput: one transaction per cycle; a tick waits only while a result is held unread.
// A set transaction produces no result and updates its channel in the cycle after acceptance.
// Reset (asynchronous, active low) turns every channel off and empties both registers.
`default_nettype none

module eight_channel_bresenham_pwm_core
    import bpwm_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_ready,
    input  wire logic       operation,
    input  wire logic [2:0] channel,
    input  wire logic [7:0] level,
    output logic            result_valid,
    input  wire logic       result_ready,
    output logic [7:0]      pattern
);

    localparam logic [CHAN_MAX-1:0] CHAN_MASK = CHAN_MAX'((1 << CHANNELS) - 1);

    // Input register: holds one accepted transaction.
    logic       s1_valid_reg, s1_valid_next;
    logic       s1_op_reg;
    logic [2:0] s1_chan_reg;
    logic [7:0] s1_level_reg;

    // Result register.
    logic                out_valid_reg, out_valid_next;
    logic [CHAN_MAX-1:0] pattern_reg;

    logic                s1_fire;
    logic                out_free;
    logic [NUM_W-1:0]    sel_num;
    logic [DEN_W-1:0]    sel_den;
    logic [CHANNELS-1:0] on_vec;
    logic [CHAN_MAX-1:0] pat_comb;
    chan_cmd_t           cmd_vec [CHANNELS];

    // The result register frees up when empty or being drained this cycle.
    assign out_free = !out_valid_reg || result_ready;

    // A set never needs the result register; a tick waits for it.
    assign s1_fire    = s1_valid_reg && ((s1_op_reg == OP_SET) || out_free);
    assign item_ready = !s1_valid_reg || s1_fire;

    // Fraction lookup from the top five bits of the level byte.
    assign sel_num = frac_num(s1_level_reg[7:3]);
    assign sel_den = frac_den(s1_level_reg[7:3]);

    genvar g;
    generate
        for (g = 0; g < CHANNELS; g++)
        begin : g_chan
            always_comb
            begin
                cmd_vec[g].tick = s1_fire && (s1_op_reg == OP_TICK);
                cmd_vec[g].load = s1_fire && (s1_op_reg == OP_SET)
                                  && (s1_chan_reg == 3'(g));
                cmd_vec[g].num  = sel_num;
                cmd_vec[g].den  = sel_den;
            end

            bpwm_chan u_chan
            (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (cmd_vec[g]),
                .on    (on_vec[g])
            );
        end

        // Drop bits of absent channels to zero.
        for (g = 0; g < CHAN_MAX; g++)
        begin : g_pat
            if (g < CHANNELS)
            begin : g_live
                assign pat_comb[g] = on_vec[g];
            end
            else
            begin : g_dead
                assign pat_comb[g] = 1'b0;
            end
        end
    endgenerate

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_ready)
            s1_valid_next = item_valid;

        out_valid_next = out_valid_reg;
        if (result_ready)
            out_valid_next = 1'b0;
        if (s1_fire && (s1_op_reg == OP_TICK))
            out_valid_next = 1'b1;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: capture on acceptance, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            s1_op_reg    <= operation;
            s1_chan_reg  <= channel;
            s1_level_reg <= level;
        end
        if (s1_fire && (s1_op_reg == OP_TICK))
            pattern_reg <= pat_comb;
    end

    assign result_valid = out_valid_reg;
    assign pattern      = pattern_reg;

    // A tick that is processed always yields a result next cycle.
    a_tick_yields: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && (s1_op_reg == OP_TICK) |=> out_valid_reg)
        else $error("tick transaction produced no result");

    // A set never creates a result.
    a_set_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && (s1_op_reg == OP_SET) && out_free |=> !out_valid_reg)
        else $error("set transaction produced a result");

    // A tick blocked by a full result register stays in the input register.
    a_tick_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && (s1_op_reg == OP_TICK) && !out_free
        |=> s1_valid_reg && (s1_op_reg == OP_TICK))
        else $error("stalled tick lost");

    // Absent channels never drive pattern bits.
    a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((pattern_reg & ~CHAN_MASK) == '0))
        else $error("pattern bit set for absent channel");

endmodule

`default_nettype wire

// File: verif/tb_eight_channel_bresenham_pwm_core.sv
`timescale 1ns / 1ps
// Testbench for eight_channel_bresenham_pwm_core: directed and random set/tick transactions,
// checked against an in-bench accumulator predictor. Depends on bpwm_pkg and the core RTL.

module tb_eight_channel_bresenham_pwm_core
    import bpwm_pkg::*;
();

    localparam int NUM_CHANNELS = 8;
    localparam int RANDOM_ITEMS = 1400;
    localparam int PHASE_ITEMS  = RANDOM_ITEMS / 4;
    // Idle time at the end of the run, for any stray pattern to surface.
    localparam int DRAIN_CYCLES = 8;

    // Reduced brightness fractions, one entry per top-five-bit level step.
    localparam logic [NUM_W-1:0] FRAC_NUMERATOR [LEVELS] = '{
        5'h00, 5'h01, 5'h01, 5'h03, 5'h01, 5'h05, 5'h03, 5'h07,
        5'h01, 5'h09, 5'h05, 5'h0b, 5'h03, 5'h0d, 5'h07, 5'h0f,
        5'h01, 5'h11, 5'h09, 5'h13, 5'h05, 5'h15, 5'h0b, 5'h17,
        5'h03, 5'h19, 5'h0d, 5'h1b, 5'h07, 5'h1d, 5'h0f, 5'h01
    };
    localparam logic [DEN_W-1:0] FRAC_DENOMINATOR [LEVELS] = '{
        6'h20, 6'h20, 6'h10, 6'h20, 6'h08, 6'h20, 6'h10, 6'h20,
        6'h04, 6'h20, 6'h10, 6'h20, 6'h08, 6'h20, 6'h10, 6'h20,
        6'h02, 6'h20, 6'h10, 6'h20, 6'h08, 6'h20, 6'h10, 6'h20,
        6'h04, 6'h20, 6'h10, 6'h20, 6'h08, 6'h20, 6'h10, 6'h01
    };

    // Mirror of the per-channel fraction and error state; holds the patterns still owed.
    class pattern_scoreboard;
        logic [NUM_W-1:0] numer [NUM_CHANNELS];
        logic [DEN_W-1:0] denom [NUM_CHANNELS];
        logic [4:0]       accum [NUM_CHANNELS];
        logic [7:0]       expected_patterns [$];
        int               mismatches;

        function new();
            for (int p = 0; p < NUM_CHANNELS; p++)
            begin
                numer[p] = '0;
                denom[p] = '0;
                accum[p] = '0;
            end
            mismatches = 0;
        endfunction

        function void note_transaction(logic op, logic [2:0] ch, logic [7:0] lvl);
            logic [IDX_W-1:0] idx;
            logic [7:0]       sum;
            logic [7:0]       pat;
            int               p;
            idx = lvl[7:3];
            if (op == OP_SET)
            begin
                if (int'(ch) < NUM_CHANNELS)
                begin
                    numer[ch] = FRAC_NUMERATOR[idx];
                    denom[ch] = FRAC_DENOMINATOR[idx];
                    accum[ch] = '0;
                end
            end
            else
            begin
                pat = '0;
                for (p = 0; p < NUM_CHANNELS; p++)
                begin
                    sum = {3'b000, accum[p]};
                    if (accum[p] < numer[p])
                    begin
                        pat[p] = 1'b1;
                        sum    = sum + {2'b00, denom[p]};
                    end
                    sum      = sum - {3'b000, numer[p]};
                    accum[p] = sum[4:0];
                end
                expected_patterns.push_back(pat);
            end
        endfunction

        function void check_pattern(logic [7:0] actual);
            logic [7:0] want;
            if (expected_patterns.size() == 0)
            begin
                $display("%0t: pattern %h arrived with none expected", $time, actual);
                mismatches++;
                return;
            end
            want = expected_patterns.pop_front();
            if (actual !== want)
            begin
                $display("%0t: pattern mismatch, expected %h actual %h", $time, want, actual);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_patterns.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_ready;
    logic       operation;
    logic [2:0] channel;
    logic [7:0] level;
    logic       result_valid;
    logic       result_ready;
    logic [7:0] pattern;

    // Idle and stall odds, in percent, per phase of the run.
    int                send_idle_pct;
    int                recv_stall_pct;
    pattern_scoreboard board;

    eight_channel_bresenham_pwm_core #(
        .CHANNELS(NUM_CHANNELS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .operation(operation),
        .channel(channel),
        .level(level),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .pattern(pattern)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Offer one transaction from a falling edge and hold it until the core takes it.
    // Returns at a falling edge with valid still high, so back-to-back items never
    // lower and raise valid in the same step.
    task automatic send_transaction(input logic op, input logic [2:0] ch, input logic [7:0] lvl);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        operation  <= op;
        channel    <= ch;
        level      <= lvl;
        do
            @(posedge clk);
        while (!item_ready);
        board.note_transaction(op, ch, lvl);
        @(negedge clk);
    endtask

    // Mostly ticks, with sets sprinkled in; bias some sets to the off and full-on steps.
    task automatic send_random_transaction();
        logic [7:0] lvl;
        lvl = 8'($urandom_range(255));
        if ($urandom_range(3) == 0)
        begin
            case ($urandom_range(7))
                0:       lvl[7:3] = 5'd0;
                1:       lvl[7:3] = 5'd31;
                default: ;
            endcase
            send_transaction(OP_SET, 3'($urandom_range(7)), lvl);
        end
        else
            send_transaction(OP_TICK, 3'($urandom_range(7)), lvl);
    endtask

    // Hold off the sender until every owed pattern has come back.
    task automatic drain_patterns();
        item_valid <= 1'b0;
        @(negedge clk);
        while (board.pending() != 0)
            @(negedge clk);
    endtask

    // Receiver: decide ready at the falling edge, check at the rising edge.
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            board.check_pattern(pattern);
    end

    initial
    begin
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        operation      = OP_TICK;
        channel        = '0;
        level          = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        board          = new();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: every channel off straight after reset.
        send_transaction(OP_TICK, 3'd0, 8'h00);
        // One level per channel: full on, off, off with low bits set, a half,
        // the finest step, a quarter, fifteen sixteenths, and an odd step with low bits.
        send_transaction(OP_SET, 3'd0, 8'hff);
        send_transaction(OP_SET, 3'd1, 8'h00);
        send_transaction(OP_SET, 3'd2, 8'h07);
        send_transaction(OP_SET, 3'd3, 8'h80);
        send_transaction(OP_SET, 3'd4, 8'h08);
        send_transaction(OP_SET, 3'd5, 8'h40);
        send_transaction(OP_SET, 3'd6, 8'hf0);
        send_transaction(OP_SET, 3'd7, 8'had);
        repeat (8)
            send_transaction(OP_TICK, 3'd7, 8'hff);
        // Reload a running channel mid-count; its error must restart from zero.
        send_transaction(OP_SET, 3'd3, 8'h7b);
        repeat (3)
            send_transaction(OP_TICK, 3'd0, 8'h00);
        drain_patterns();

        // Random phases: no idling, slow sender, slow receiver, both slightly uneven.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 75;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 75;
                end
                default:
                begin
                    send_idle_pct  = 6;
                    recv_stall_pct = 6;
                end
            endcase
            repeat (PHASE_ITEMS)
                send_random_transaction();
            drain_patterns();
        end

        // Let any stray result surface before the verdict.
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("eight_channel_bresenham_pwm_core test passed");
        else
            $display("eight_channel_bresenham_pwm_core test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #1000000;
        $display("eight_channel_bresenham_pwm_core test failed");
        $finish;
    end

endmodule
